/* sv/lrto_pkg.sv */
// Package: shared constants, types and tables for the lidar ring time offset block.
package lrto_pkg;

    localparam int RING_COUNT_DEF = 16;
    localparam int STEPS = 16;
    localparam int YAW_W = 17;
    localparam int LTIME_W = 18;
    localparam int ANG_W = 25;
    localparam int CW = 43;
    localparam logic signed [ANG_W-1:0] QUARTER_FINE = 25'sd5898240;
    localparam logic signed [ANG_W-1:0] YAW_LIMIT = 25'sd46080;
    localparam logic [17:0] FULL_TURN_YAW = 18'd92160;
    localparam logic [17:0] TURN_US = 18'd99723;
    localparam logic [11:0] TIME_NUM = 12'd3125;
    localparam logic [10:0] TIME_HALF = 11'd1444;
    localparam logic [26:0] TIME_RECIP = 27'd95179331;

    localparam logic [0:0] CFG_KEEP_EVERY = 1'b0;
    localparam logic [0:0] CFG_MIN_RANGE = 1'b1;

    typedef struct packed {
        logic signed [YAW_W-1:0] first_yaw;
        logic [LTIME_W-1:0] last_time;
    } ring_entry_t;

    function automatic logic signed [ANG_W-1:0] angle_tab(input logic [3:0] i);
        logic signed [ANG_W-1:0] a;
        case (i)
            4'd0: a = 25'sd2949120;
            4'd1: a = 25'sd1740967;
            4'd2: a = 25'sd919879;
            4'd3: a = 25'sd466945;
            4'd4: a = 25'sd234379;
            4'd5: a = 25'sd117304;
            4'd6: a = 25'sd58666;
            4'd7: a = 25'sd29335;
            4'd8: a = 25'sd14668;
            4'd9: a = 25'sd7334;
            4'd10: a = 25'sd3667;
            4'd11: a = 25'sd1833;
            4'd12: a = 25'sd917;
            4'd13: a = 25'sd458;
            4'd14: a = 25'sd229;
            default: a = 25'sd115;
        endcase
        return a;
    endfunction

endpackage

/* sv/lrto_cordic.sv */
// Iterative CORDIC vectoring unit giving yaw in 1/256 degree.
module lrto_cordic (
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  logic signed [19:0] x_in,
    input  logic signed [19:0] y_in,
    output logic done,
    output logic signed [lrto_pkg::YAW_W-1:0] yaw
);
    import lrto_pkg::*;

    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic [3:0] i_reg;
    logic busy_reg, zero_reg, done_reg;
    logic signed [YAW_W-1:0] yaw_reg;
    logic signed [CW-1:0] dx, dy;
    logic signed [ANG_W-1:0] zr;

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign zr = (z_reg + 25'sd128) >>> 8;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                i_reg <= 4'd0;
                zero_reg <= (x_in == 20'sd0) && (y_in == 20'sd0);
                if (x_in < 0) begin
                    if (y_in >= 0) begin
                        x_reg <= {{3{y_in[19]}}, y_in, 20'd0};
                        y_reg <= -{{3{x_in[19]}}, x_in, 20'd0};
                        z_reg <= QUARTER_FINE;
                    end else begin
                        x_reg <= -{{3{y_in[19]}}, y_in, 20'd0};
                        y_reg <= {{3{x_in[19]}}, x_in, 20'd0};
                        z_reg <= -QUARTER_FINE;
                    end
                end else begin
                    x_reg <= {{3{x_in[19]}}, x_in, 20'd0};
                    y_reg <= {{3{y_in[19]}}, y_in, 20'd0};
                    z_reg <= '0;
                end
            end else if (busy_reg) begin
                if (y_reg >= 0) begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + angle_tab(i_reg);
                end else begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - angle_tab(i_reg);
                end
                i_reg <= i_reg + 4'd1;
                if (i_reg == 4'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (done_reg) begin
            if (zero_reg) begin
                yaw_reg <= '0;
            end else if (zr > YAW_LIMIT) begin
                yaw_reg <= YAW_LIMIT[YAW_W-1:0];
            end else if (zr < -YAW_LIMIT) begin
                yaw_reg <= -YAW_LIMIT[YAW_W-1:0];
            end else begin
                yaw_reg <= zr[YAW_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign yaw = yaw_reg;
endmodule

/* sv/lrto_ring_mem.sv */
// Ring store: synchronous memory of first yaw and last time, with valid bits.
module lrto_ring_mem #(
    parameter int RING_COUNT = lrto_pkg::RING_COUNT_DEF,
    parameter int RW = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic clear,
    input  logic rd_en,
    input  logic [RW-1:0] rd_addr,
    output lrto_pkg::ring_entry_t rd_data,
    output logic rd_seen,
    input  logic wr_en,
    input  logic [RW-1:0] wr_addr,
    input  lrto_pkg::ring_entry_t wr_data
);
    import lrto_pkg::*;

    ring_entry_t mem [RING_COUNT];
    logic [RING_COUNT-1:0] seen_reg;
    ring_entry_t rd_reg;
    logic rd_seen_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            rd_seen_reg <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_seen_reg <= seen_reg[rd_addr] && !clear;
            end
            if (clear) begin
                seen_reg <= '0;
            end else if (wr_en) begin
                seen_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_reg;
    assign rd_seen = rd_seen_reg;
endmodule

/* sv/lidar_ring_time_offset.sv */
// Top level: per-ring point timing for a spinning lidar.
// One point at a time. A given-offset point or an out-of-range ring goes
// straight to the range check; a yaw-mode point first passes the 16-step
// iterative CORDIC, one ring store read-modify-write and a reciprocal
// multiplication (product, then quotient, then ring store write) for the
// divide of the lag product by 2888; a ring's first point skips the divide.
// The range check runs through one shared squarer, on x, then y, then z. A
// result waits in the output register while the next point is taken in; a
// point that finds the output register still full stalls until it drains.
// Frame start clears the ring store valid bits at once.
module lidar_ring_time_offset #(
    parameter int RING_COUNT = lrto_pkg::RING_COUNT_DEF,
    parameter int RW = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic [18:0] cfg_data,
    input  logic s_valid,
    output logic s_ready,
    input  logic s_frame_start,
    input  logic s_offset_given,
    input  logic signed [19:0] s_pos_x,
    input  logic signed [19:0] s_pos_y,
    input  logic signed [19:0] s_pos_z,
    input  logic [7:0] s_intensity,
    input  logic [3:0] s_ring,
    input  logic [19:0] s_point_offset_us,
    input  logic [62:0] s_frame_time_us,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [19:0] m_out_x,
    output logic signed [19:0] m_out_y,
    output logic signed [19:0] m_out_z,
    output logic [7:0] m_out_intensity,
    output logic [62:0] m_out_time_us
);
    import lrto_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CORDIC = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_DIV = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0] state_reg;
    logic [7:0] keep_reg, dcount_reg;
    logic [18:0] minr_reg;
    logic signed [19:0] x_reg, y_reg, z_reg;
    logic [7:0] inten_reg;
    logic [3:0] ring_reg;
    logic given_reg, emit_ok_reg, valid_reg;
    logic [62:0] time_reg;
    logic [1:0] rstep_reg;
    logic [41:0] r2_reg;
    logic [37:0] m2_reg;
    logic [1:0] dstep_reg;
    logic [28:0] num_reg;
    logic [52:0] prod_reg;
    logic [17:0] quo_reg;
    logic [LTIME_W-1:0] last_reg;
    logic signed [YAW_W-1:0] yaw_reg;
    logic m_valid_reg;
    logic signed [19:0] ox_reg, oy_reg, oz_reg;
    logic [7:0] oi_reg;
    logic [62:0] ot_reg;

    logic accept, cordic_done, rd_seen, wr_en;
    logic signed [YAW_W-1:0] yaw;
    ring_entry_t rd_data, wr_data;
    logic [7:0] keep_eff;
    logic ring_ok;
    logic signed [19:0] sq_in;
    logic [39:0] sq;
    logic [17:0] lag;
    logic signed [YAW_W:0] diff;
    logic [17:0] t_fix;
    logic emit_hit, emit_load;

    assign s_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept = s_valid && s_ready;
    assign keep_eff = (keep_reg == 8'd0) ? 8'd1 : keep_reg;
    assign ring_ok = ({28'd0, s_ring} < RING_COUNT);

    lrto_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn),
        .start(accept && !s_offset_given && ring_ok),
        .x_in(s_pos_x), .y_in(s_pos_y),
        .done(cordic_done), .yaw(yaw)
    );

    lrto_ring_mem #(.RING_COUNT(RING_COUNT), .RW(RW)) u_mem (
        .aclk(aclk), .aresetn(aresetn),
        .clear(accept && s_frame_start),
        .rd_en(accept), .rd_addr(RW'(s_ring)),
        .rd_data(rd_data), .rd_seen(rd_seen),
        .wr_en(wr_en), .wr_addr(RW'(ring_reg)), .wr_data(wr_data)
    );

    always_comb begin
        case (rstep_reg)
            2'd0: sq_in = x_reg;
            2'd1: sq_in = y_reg;
            default: sq_in = z_reg;
        endcase
    end
    assign sq = 40'(sq_in * sq_in);

    assign diff = {yaw_reg[YAW_W-1], yaw_reg} - {yaw[YAW_W-1], yaw};
    always_comb begin
        if (yaw > yaw_reg) begin
            lag = 18'(diff) + FULL_TURN_YAW;
        end else begin
            lag = 18'(diff);
        end
    end
    assign t_fix = (quo_reg < last_reg) ? quo_reg + TURN_US : quo_reg;

    assign emit_hit = valid_reg && emit_ok_reg && (r2_reg > {4'd0, m2_reg});
    assign emit_load = (state_reg == ST_EMIT) && emit_hit && (!m_valid_reg || m_ready);

    always_comb begin
        wr_en = 1'b0;
        wr_data.first_yaw = yaw_reg;
        wr_data.last_time = t_fix;
        if (state_reg == ST_READ && !valid_reg) begin
            wr_en = 1'b1;
            wr_data.first_yaw = yaw;
            wr_data.last_time = '0;
        end else if (state_reg == ST_DIV && dstep_reg == 2'd2 && valid_reg) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            keep_reg <= 8'd1;
            minr_reg <= '0;
            dcount_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_KEEP_EVERY: keep_reg <= cfg_data[7:0];
                    CFG_MIN_RANGE: minr_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        logic [7:0] idx;
                        idx = s_frame_start ? 8'd0 : dcount_reg;
                        emit_ok_reg <= (idx == 8'd0);
                        dcount_reg <= ({1'b0, idx} + 9'd1 >= {1'b0, keep_eff}) ? 8'd0
                                      : idx + 8'd1;
                        x_reg <= s_pos_x;
                        y_reg <= s_pos_y;
                        z_reg <= s_pos_z;
                        inten_reg <= s_intensity;
                        ring_reg <= s_ring;
                        given_reg <= s_offset_given;
                        time_reg <= s_frame_time_us + {43'd0, s_point_offset_us};
                        rstep_reg <= 2'd0;
                        r2_reg <= '0;
                        m2_reg <= 38'(minr_reg * minr_reg);
                        valid_reg <= 1'b1;
                        if (s_offset_given) begin
                            state_reg <= ST_RANGE;
                        end else if (!ring_ok) begin
                            valid_reg <= 1'b0;
                            state_reg <= ST_RANGE;
                        end else begin
                            state_reg <= ST_CORDIC;
                        end
                    end
                end
                ST_CORDIC: begin
                    if (cordic_done) begin
                        state_reg <= ST_READ;
                    end else begin
                        yaw_reg <= rd_data.first_yaw;
                        last_reg <= rd_data.last_time;
                        valid_reg <= rd_seen;
                    end
                end
                ST_READ: begin
                    if (!valid_reg) begin
                        state_reg <= ST_RANGE;
                    end else begin
                        num_reg <= 29'(lag * TIME_NUM) + {18'd0, TIME_HALF};
                        dstep_reg <= 2'd0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    case (dstep_reg)
                        2'd0: begin
                            prod_reg <= 53'(num_reg[28:3] * TIME_RECIP);
                            dstep_reg <= 2'd1;
                        end
                        2'd1: begin
                            quo_reg <= prod_reg[52:35];
                            dstep_reg <= 2'd2;
                        end
                        default: begin
                            time_reg <= {45'd0, t_fix};
                            state_reg <= ST_RANGE;
                        end
                    endcase
                end
                ST_RANGE: begin
                    r2_reg <= r2_reg + {2'd0, sq};
                    rstep_reg <= rstep_reg + 2'd1;
                    if (rstep_reg == 2'd2) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!emit_hit) begin
                        state_reg <= ST_IDLE;
                    end else if (emit_load) begin
                        ox_reg <= x_reg;
                        oy_reg <= y_reg;
                        oz_reg <= z_reg;
                        oi_reg <= inten_reg;
                        ot_reg <= time_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_x = ox_reg;
    assign m_out_y = oy_reg;
    assign m_out_z = oz_reg;
    assign m_out_intensity = oi_reg;
    assign m_out_time_us = ot_reg;
endmodule
